// ----- rtl/tmp_pkg.sv -----
// Shared types, codes and fixed-point helpers for the trapezoidal motion profile core.
// Used by tmp_mul and trapezoidal_motion_profile_core; depends on nothing else.
package tmp_pkg;

   // Field and register widths.
   localparam int VAL_W  = 32;
   localparam int CSR_W  = 31;
   localparam int IDX_W  = 3;
   localparam int FUNC_W = 3;
   localparam int MODE_W = 3;
   localparam int TS_W   = 24;

   // Serial multiplier widths: magnitude operand, multiplier operand, product.
   localparam int MUL_A_W   = 33;
   localparam int MUL_B_W   = 32;
   localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
   localparam int MUL_CNT_W = $clog2(MUL_B_W);

   // Item function codes.
   localparam logic [FUNC_W-1:0] FUNC_TICK = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_ABS  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_REL  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_JOG  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_STOP = 3'd4;

   // Motion modes as reported on the result channel.
   localparam logic [MODE_W-1:0] MODE_IDLE    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PRIME   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_PROFILE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_JOG     = 3'd3;
   localparam logic [MODE_W-1:0] MODE_STOP    = 3'd4;

   // Register indexes.
   localparam logic [IDX_W-1:0] REG_VEL_LIMIT   = 3'd0;
   localparam logic [IDX_W-1:0] REG_ACCEL_LIMIT = 3'd1;
   localparam logic [IDX_W-1:0] REG_TICK_SEC    = 3'd2;
   localparam logic [IDX_W-1:0] REG_TICK_RATE   = 3'd3;
   localparam logic [IDX_W-1:0] REG_ROTARY      = 3'd4;

   // Register reset values.
   localparam logic [CSR_W-1:0] RST_VEL_LIMIT   = 31'd65536;
   localparam logic [CSR_W-1:0] RST_ACCEL_LIMIT = 31'd65536;
   localparam logic [TS_W-1:0]  RST_TICK_SEC    = 24'd167772;
   localparam logic [CSR_W-1:0] RST_TICK_RATE   = 31'd6553600;
   localparam logic [CSR_W-1:0] RST_ROTARY      = 31'd65536;

   // Saturate a widened sum to the signed 32-bit range.
   function automatic logic signed [VAL_W-1:0] sat34(input logic signed [VAL_W+1:0] x);
      if (x > 34'sh0_7FFF_FFFF)
         return 32'sh7FFF_FFFF;
      else if (x < 34'sh3_8000_0000)
         return 32'sh8000_0000;
      else
         return x[VAL_W-1:0];
   endfunction

   // Magnitude of a signed 33-bit value.
   function automatic logic [MUL_A_W-1:0] abs33(input logic signed [MUL_A_W-1:0] x);
      return x[MUL_A_W-1] ? MUL_A_W'(-x) : MUL_A_W'(x);
   endfunction

   // Drop the fraction of a magnitude product, apply the sign and saturate.
   function automatic logic signed [VAL_W-1:0] mul_sat(input logic [MUL_P_W-1:0] p,
                                                       input logic neg, input logic sh24);
      logic [MUL_P_W-1:0] s;
      s = sh24 ? (p >> 24) : (p >> 16);
      if (neg) begin
         if (s > 65'h0_8000_0000)
            return 32'sh8000_0000;
         else
            return -$signed(s[VAL_W-1:0]);
      end else if (s > 65'h0_7FFF_FFFF) begin
         return 32'sh7FFF_FFFF;
      end else begin
         return $signed(s[VAL_W-1:0]);
      end
   endfunction

endpackage

// ----- rtl/tmp_mul.sv -----
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on tmp_pkg for the operand and product widths.
module tmp_mul (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         mul_go,
   input  logic [tmp_pkg::MUL_A_W-1:0]  mul_a,
   input  logic [tmp_pkg::MUL_B_W-1:0]  mul_b,
   output logic                         mul_done,
   output logic [tmp_pkg::MUL_P_W-1:0]  mul_prod
);
   import tmp_pkg::*;

   logic [MUL_P_W-1:0]   acc_ff, acc_in;
   logic [MUL_A_W-1:0]   a_ff, a_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [MUL_A_W:0]     sum;

   // Add the multiplicand into the high half when the current bit is set.
   always_comb begin
      sum = {1'b0, acc_ff[MUL_P_W-1:MUL_B_W]} + (acc_ff[0] ? {1'b0, a_ff} : '0);
   end

   // Load on start, then shift one bit per cycle until all bits are used.
   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (mul_go) begin
         acc_in  = {{MUL_A_W{1'b0}}, mul_b};
         a_in    = mul_a;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = {sum, acc_ff[MUL_B_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == MUL_CNT_W'(MUL_B_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
   end

   assign mul_done = done_ff;
   assign mul_prod = acc_ff;

endmodule

// ----- rtl/trapezoidal_motion_profile_core.sv -----
// Trapezoidal motion profile core: item sequencer around one bit-serial multiplier.
// Each product is formed serially in tmp_mul; a command or idle tick needs one product, a
// priming or arrival tick two, a jog or stop tick three and a profiling tick six; the next
// item is taken in the idle state once the result has gone to the output register.
// Results wait in an output register, so a new item is taken while one is unread.
// Synchronous active-high reset: position, velocity and target zero, mode idle,
// registers at their defaults. Depends on tmp_pkg and tmp_mul.
module trapezoidal_motion_profile_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [tmp_pkg::FUNC_W-1:0]          req_func,
   input  logic signed [tmp_pkg::VAL_W-1:0]    req_goal,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [tmp_pkg::VAL_W-1:0]    rsp_position_out,
   output logic signed [tmp_pkg::VAL_W-1:0]    rsp_velocity_out,
   output logic signed [tmp_pkg::VAL_W-1:0]    rsp_motor_speed,
   output logic [tmp_pkg::MODE_W-1:0]          rsp_mode_out,
   output logic                                rsp_reached,
   input  logic                                csr_wen,
   input  logic [tmp_pkg::IDX_W-1:0]           csr_index,
   input  logic [tmp_pkg::CSR_W-1:0]           csr_wdata
);
   import tmp_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b00_0000_0001,
      ST_DECODE = 10'b00_0000_0010,
      ST_DV     = 10'b00_0000_0100,
      ST_BRK_A  = 10'b00_0000_1000,
      ST_BRK_B  = 10'b00_0001_0000,
      ST_STEP   = 10'b00_0010_0000,
      ST_VEL    = 10'b00_0100_0000,
      ST_MSTART = 10'b00_1000_0000,
      ST_MOTOR  = 10'b01_0000_0000,
      ST_OUT    = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [CSR_W-1:0] vlim_ff, alim_ff, rate_ff, rot_ff;
   logic [TS_W-1:0]  ts_ff;

   // Motion state.
   logic signed [VAL_W-1:0] pos_ff, pos_in, vel_ff, vel_in, tgt_ff, tgt_in;
   logic                    up_ff, up_in, flag_ff, flag_in;
   logic [MODE_W-1:0]       mode_ff, mode_in;

   // Per-item working registers.
   logic [FUNC_W-1:0]       func_ff, func_in;
   logic signed [VAL_W-1:0] goal_ff, goal_in, dv_ff, dv_in, old_ff, old_in;
   logic [MUL_P_W-1:0]      ah_ff, ah_in;
   logic                    prof_ff, prof_in, mneg_ff, mneg_in, msh_ff, msh_in;

   // Result register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [VAL_W-1:0] rpos_ff, rpos_in, rvel_ff, rvel_in, rmot_ff, rmot_in;
   logic [MODE_W-1:0]       rmode_ff, rmode_in;
   logic                    rflag_ff, rflag_in;

   // Multiplier hookup.
   logic                    mul_go, mul_done;
   logic [MUL_A_W-1:0]      mul_a;
   logic [MUL_B_W-1:0]      mul_b;
   logic [MUL_P_W-1:0]      mul_prod;
   logic signed [VAL_W-1:0] mres;

   // Datapath helpers.
   logic signed [VAL_W-1:0] dv_now, v_plus, v_minus, nv, s_val, s_tmp, vmax, pnew;
   logic signed [MUL_A_W-1:0] dp;
   logic                    stop_end, brake, reach_now, accel_ok;

   tmp_mul u_mul (
      .clock    (clock),
      .reset    (reset),
      .mul_go   (mul_go),
      .mul_a    (mul_a),
      .mul_b    (mul_b),
      .mul_done (mul_done),
      .mul_prod (mul_prod)
   );

   assign mres = mul_sat(mul_prod, mneg_ff, msh_ff);

   // Velocity arithmetic shared by the jog, stop and profile steps.
   always_comb begin
      dv_now  = (state_ff == ST_DV) ? mres : dv_ff;
      vmax    = $signed({1'b0, vlim_ff});
      v_plus  = sat34({{2{vel_ff[VAL_W-1]}}, vel_ff} + {{2{dv_now[VAL_W-1]}}, dv_now});
      v_minus = sat34({{2{vel_ff[VAL_W-1]}}, vel_ff} - {{2{dv_now[VAL_W-1]}}, dv_now});
      reach_now = up_ff ? (pos_ff >= tgt_ff) : (pos_ff <= tgt_ff);

      // New velocity for a jog or stop tick.
      stop_end = 1'b0;
      if (mode_ff == MODE_JOG) begin
         if (up_ff)
            nv = (v_plus > tgt_ff) ? tgt_ff : v_plus;
         else
            nv = (v_minus < tgt_ff) ? tgt_ff : v_minus;
      end else if (up_ff) begin
         nv = v_minus;
         if (v_minus <= 0) begin
            nv       = '0;
            stop_end = 1'b1;
         end
      end else begin
         nv = v_plus;
         if (v_plus >= 0) begin
            nv       = '0;
            stop_end = 1'b1;
         end
      end

      // Profile speed choice: brake, accelerate or cruise.
      brake    = (ah_ff >= mul_prod);
      accel_ok = ({1'b0, abs33({vel_ff[VAL_W-1], vel_ff})} < {2'b00, vlim_ff}) ||
                 ((tgt_ff < pos_ff) && (vel_ff > 0)) || ((tgt_ff > pos_ff) && (vel_ff < 0));
      s_tmp    = '0;
      if (brake) begin
         if (vel_ff < 0)
            s_val = v_plus;
         else if (vel_ff > 0)
            s_val = v_minus;
         else
            s_val = '0;
      end else if (accel_ok) begin
         if (tgt_ff > pos_ff) begin
            s_val = (v_plus > vmax) ? vmax : v_plus;
         end else begin
            s_tmp = v_minus;
            s_val = (abs33({s_tmp[VAL_W-1], s_tmp}) > {2'b00, vlim_ff}) ? -vmax : s_tmp;
         end
      end else begin
         s_val = (tgt_ff > pos_ff) ? vmax : -vmax;
      end

      // Position after the step, clamped at the target on a profiling tick.
      pnew = sat34({{2{pos_ff[VAL_W-1]}}, pos_ff} + {{2{mres[VAL_W-1]}}, mres});
      if (prof_ff && (up_ff ? (pnew >= tgt_ff) : (pnew <= tgt_ff)))
         pnew = tgt_ff;
      dp = {pnew[VAL_W-1], pnew} - {old_ff[VAL_W-1], old_ff};
   end

   // Item sequencer.
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      vel_in       = vel_ff;
      tgt_in       = tgt_ff;
      up_in        = up_ff;
      flag_in      = flag_ff;
      mode_in      = mode_ff;
      func_in      = func_ff;
      goal_in      = goal_ff;
      dv_in        = dv_ff;
      old_in       = old_ff;
      ah_in        = ah_ff;
      prof_in      = prof_ff;
      mneg_in      = mneg_ff;
      msh_in       = msh_ff;
      mul_go       = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      rpos_in      = rpos_ff;
      rvel_in      = rvel_ff;
      rmot_in      = rmot_ff;
      rmode_in     = rmode_ff;
      rflag_in     = rflag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in  = req_func;
               goal_in  = req_goal;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_MSTART;
            prof_in  = 1'b0;
            case (func_ff)
               FUNC_ABS, FUNC_REL: begin
                  if (func_ff == FUNC_ABS) begin
                     tgt_in = goal_ff;
                     up_in  = !(goal_ff < pos_ff);
                  end else begin
                     tgt_in = sat34({{2{pos_ff[VAL_W-1]}}, pos_ff} +
                                    {{2{goal_ff[VAL_W-1]}}, goal_ff});
                     up_in  = (goal_ff >= 0);
                  end
                  vel_in  = '0;
                  flag_in = 1'b0;
                  mode_in = MODE_PRIME;
               end
               FUNC_JOG: begin
                  tgt_in  = goal_ff;
                  up_in   = (goal_ff >= 0);
                  flag_in = 1'b0;
                  mode_in = MODE_JOG;
               end
               FUNC_STOP: begin
                  if (mode_ff != MODE_IDLE) begin
                     mode_in = MODE_STOP;
                     flag_in = 1'b0;
                  end
               end
               default: begin
                  // Tick or spare function code: work out the velocity change per tick first.
                  if (mode_ff != MODE_IDLE) begin
                     mul_go   = 1'b1;
                     mul_a    = MUL_A_W'(alim_ff);
                     mul_b    = MUL_B_W'(ts_ff);
                     mneg_in  = 1'b0;
                     msh_in   = 1'b1;
                     state_in = ST_DV;
                  end
               end
            endcase
         end
         ST_DV: begin
            if (mul_done) begin
               dv_in = mres;
               if (mode_ff == MODE_PRIME || mode_ff == MODE_PROFILE) begin
                  if (reach_now) begin
                     pos_in   = tgt_ff;
                     vel_in   = '0;
                     flag_in  = 1'b1;
                     mode_in  = MODE_IDLE;
                     state_in = ST_MSTART;
                  end else if (mode_ff == MODE_PRIME) begin
                     mode_in  = MODE_PROFILE;
                     state_in = ST_MSTART;
                  end else begin
                     // Braking test, first the squared speed.
                     old_in   = pos_ff;
                     mul_go   = 1'b1;
                     mul_a    = abs33({vel_ff[VAL_W-1], vel_ff});
                     mul_b    = MUL_B_W'(abs33({vel_ff[VAL_W-1], vel_ff}));
                     state_in = ST_BRK_A;
                  end
               end else begin
                  // Jog or stop: new velocity, then its position step.
                  vel_in = nv;
                  if (mode_ff == MODE_STOP && stop_end)
                     mode_in = MODE_IDLE;
                  mul_go   = 1'b1;
                  mul_a    = abs33({nv[VAL_W-1], nv});
                  mul_b    = MUL_B_W'(ts_ff);
                  mneg_in  = nv[VAL_W-1];
                  msh_in   = 1'b1;
                  state_in = ST_STEP;
               end
            end
         end
         ST_BRK_A: begin
            if (mul_done) begin
               ah_in    = mul_prod;
               mul_go   = 1'b1;
               mul_a    = abs33({tgt_ff[VAL_W-1], tgt_ff} - {pos_ff[VAL_W-1], pos_ff});
               mul_b    = {alim_ff, 1'b0};
               state_in = ST_BRK_B;
            end
         end
         ST_BRK_B: begin
            if (mul_done) begin
               prof_in  = 1'b1;
               mul_go   = 1'b1;
               mul_a    = abs33({s_val[VAL_W-1], s_val});
               mul_b    = MUL_B_W'(ts_ff);
               mneg_in  = s_val[VAL_W-1];
               msh_in   = 1'b1;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (mul_done) begin
               pos_in = pnew;
               if (prof_ff) begin
                  mul_go   = 1'b1;
                  mul_a    = abs33(dp);
                  mul_b    = MUL_B_W'(rate_ff);
                  mneg_in  = dp[MUL_A_W-1];
                  msh_in   = 1'b0;
                  state_in = ST_VEL;
               end else begin
                  state_in = ST_MSTART;
               end
            end
         end
         ST_VEL: begin
            if (mul_done) begin
               vel_in   = mres;
               state_in = ST_MSTART;
            end
         end
         ST_MSTART: begin
            mul_go   = 1'b1;
            mul_a    = abs33({vel_ff[VAL_W-1], vel_ff});
            mul_b    = MUL_B_W'(rot_ff);
            mneg_in  = vel_ff[VAL_W-1];
            msh_in   = 1'b0;
            state_in = ST_MOTOR;
         end
         ST_MOTOR: begin
            if (mul_done)
               state_in = ST_OUT;
         end
         ST_OUT: begin
            // Hand the item over once the result register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rpos_in      = pos_ff;
               rvel_in      = vel_ff;
               rmot_in      = mres;
               rmode_in     = mode_ff;
               rflag_in     = flag_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         vel_ff       <= '0;
         tgt_ff       <= '0;
         up_ff        <= 1'b1;
         flag_ff      <= 1'b0;
         mode_ff      <= MODE_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         vel_ff       <= vel_in;
         tgt_ff       <= tgt_in;
         up_ff        <= up_in;
         flag_ff      <= flag_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff  <= func_in;
      goal_ff  <= goal_in;
      dv_ff    <= dv_in;
      old_ff   <= old_in;
      ah_ff    <= ah_in;
      prof_ff  <= prof_in;
      mneg_ff  <= mneg_in;
      msh_ff   <= msh_in;
      rpos_ff  <= rpos_in;
      rvel_ff  <= rvel_in;
      rmot_ff  <= rmot_in;
      rmode_ff <= rmode_in;
      rflag_ff <= rflag_in;
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         vlim_ff <= RST_VEL_LIMIT;
         alim_ff <= RST_ACCEL_LIMIT;
         ts_ff   <= RST_TICK_SEC;
         rate_ff <= RST_TICK_RATE;
         rot_ff  <= RST_ROTARY;
      end else if (csr_wen) begin
         case (csr_index)
            REG_VEL_LIMIT:   vlim_ff <= csr_wdata;
            REG_ACCEL_LIMIT: alim_ff <= csr_wdata;
            REG_TICK_SEC:    ts_ff   <= csr_wdata[TS_W-1:0];
            REG_TICK_RATE:   rate_ff <= csr_wdata;
            REG_ROTARY:      rot_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_position_out = rpos_ff;
   assign rsp_velocity_out = rvel_ff;
   assign rsp_motor_speed  = rmot_ff;
   assign rsp_mode_out     = rmode_ff;
   assign rsp_reached      = rflag_ff;

   // The finished flag is only ever held while the move is idle.
   a_flag_idle: assert property (@(posedge clock) disable iff (reset)
      flag_ff |-> (mode_ff == MODE_IDLE))
      else $error("finished flag set outside idle mode");

   // An accepted item is decoded in the next cycle.
   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_DECODE))
      else $error("accepted item not decoded");

   // A product only completes while the sequencer waits for one.
   a_done_wait: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_DV || state_ff == ST_BRK_A || state_ff == ST_BRK_B ||
                    state_ff == ST_STEP || state_ff == ST_VEL || state_ff == ST_MOTOR))
      else $error("multiplier finished outside a wait state");

   // The mode register never holds a code beyond stopping.
   a_mode_range: assert property (@(posedge clock) disable iff (reset)
      mode_ff <= MODE_STOP)
      else $error("mode code out of range");

endmodule

// ----- tb/tb_trapezoidal_motion_profile_core.sv -----
// Self-checking testbench for trapezoidal_motion_profile_core: directed and random
// command/tick items under random handshake idling, checked against a built-in predictor.
// Depends on tmp_pkg and the core RTL only.
module tb_trapezoidal_motion_profile_core;
   timeunit 1ns;
   timeprecision 1ps;
   import tmp_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int LONG_HOLD      = 600;
   localparam int PHASE_ITEMS    = 180;

   typedef struct {
      logic signed [VAL_W-1:0] position;
      logic signed [VAL_W-1:0] velocity;
      logic signed [VAL_W-1:0] motor;
      logic [MODE_W-1:0]       mode;
      logic                    reached;
   } motion_result_type;

   // Scoreboard: carries its own copy of the motion state and registers, and a
   // queue of the results that the accepted items must produce.
   class motion_scoreboard_type;
      longint          vel_limit, accel_limit, tick_sec, tick_rate, rotary;
      longint          position, velocity, target;
      bit              moving_up, done;
      logic [MODE_W-1:0] mode;
      motion_result_type expected_q[$];
      int              errors;
      int              results_seen;
      int              reached_seen;

      function new();
         vel_limit   = RST_VEL_LIMIT;
         accel_limit = RST_ACCEL_LIMIT;
         tick_sec    = RST_TICK_SEC;
         tick_rate   = RST_TICK_RATE;
         rotary      = RST_ROTARY;
         position = 0;
         velocity = 0;
         target = 0;
         moving_up = 1;
         done = 0;
         mode = MODE_IDLE;
      endfunction

      function void write_reg(logic [IDX_W-1:0] idx, logic [CSR_W-1:0] value);
         case (idx)
            REG_VEL_LIMIT:   vel_limit = value;
            REG_ACCEL_LIMIT: accel_limit = value;
            REG_TICK_SEC:    tick_sec = value[TS_W-1:0];
            REG_TICK_RATE:   tick_rate = value;
            REG_ROTARY:      rotary = value;
            default: ;
         endcase
      endfunction

      function longint sat32(longint x);
         if (x > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
         if (x < -64'sh8000_0000) return -64'sh8000_0000;
         return x;
      endfunction

      // Exact product shifted right, truncated toward zero, magnitude capped at 2^62.
      function longint scaled_mul(longint a, longint b, int shift);
         logic [127:0] m;
         logic [127:0] p;
         bit neg;
         neg = a < 0;
         m = neg ? 128'(-a) : 128'(a);
         p = (m * 128'(b)) >> shift;
         if (p > (128'd1 << 62)) p = 128'd1 << 62;
         return neg ? -longint'(p) : longint'(p);
      endfunction

      function longint time_step(longint v);
         return sat32(scaled_mul(v, tick_sec, 24));
      endfunction

      function longint magnitude(longint x);
         return x < 0 ? -x : x;
      endfunction

      // One trapezoid step: brake, accelerate or cruise, clamp at the target, then set the velocity from the step.
      function void trapezoid_step();
         longint p, old, v, vmax, dv, s, vm, d;
         bit brake;
         p = position;
         old = position;
         v = velocity;
         vmax = sat32(vel_limit);
         dv = time_step(accel_limit);
         vm = magnitude(v);
         d = magnitude(target - p);
         brake = (128'(vm) * 128'(vm)) >= (128'(2 * accel_limit) * 128'(d));
         if (brake) begin
            if (v < 0) p = sat32(p + time_step(sat32(v + dv)));
            else if (v > 0) p = sat32(p + time_step(sat32(v - dv)));
         end else if (vm < vmax || (target < p && v > 0) || (target > p && v < 0)) begin
            if (target > p) begin
               s = sat32(v + dv);
               if (s > vmax) s = vmax;
            end else begin
               s = sat32(v - dv);
               if (magnitude(s) > vmax) s = -vmax;
            end
            p = sat32(p + time_step(s));
         end else begin
            p = sat32(p + time_step(target > p ? vmax : -vmax));
         end
         if (moving_up ? p >= target : p <= target) p = target;
         position = p;
         velocity = sat32(scaled_mul(p - old, tick_rate, 16));
      endfunction

      function void sample_tick();
         longint dv;
         dv = time_step(accel_limit);
         if (mode == MODE_PRIME || mode == MODE_PROFILE) begin
            if (moving_up ? position >= target : position <= target) begin
               position = target;
               velocity = 0;
               done = 1;
               mode = MODE_IDLE;
            end else if (mode == MODE_PRIME) begin
               mode = MODE_PROFILE;
            end else begin
               trapezoid_step();
            end
         end else if (mode == MODE_JOG) begin
            if (moving_up) begin
               velocity = sat32(velocity + dv);
               if (velocity > target) velocity = target;
            end else begin
               velocity = sat32(velocity - dv);
               if (velocity < target) velocity = target;
            end
            position = sat32(position + time_step(velocity));
         end else if (mode == MODE_STOP) begin
            if (moving_up) begin
               velocity = sat32(velocity - dv);
               if (velocity <= 0) begin
                  velocity = 0;
                  mode = MODE_IDLE;
               end
            end else begin
               velocity = sat32(velocity + dv);
               if (velocity >= 0) begin
                  velocity = 0;
                  mode = MODE_IDLE;
               end
            end
            position = sat32(position + time_step(velocity));
         end
      endfunction

      // Note an accepted item: update the state and queue the result it causes.
      function void note_item(logic [FUNC_W-1:0] func, logic signed [VAL_W-1:0] goal_in);
         longint goal;
         motion_result_type r;
         goal = goal_in;
         case (func)
            FUNC_ABS, FUNC_REL: begin
               if (func == FUNC_ABS) begin
                  target = goal;
                  moving_up = !(goal < position);
               end else begin
                  target = sat32(position + goal);
                  moving_up = goal >= 0;
               end
               velocity = 0;
               done = 0;
               mode = MODE_PRIME;
            end
            FUNC_JOG: begin
               target = goal;
               moving_up = goal >= 0;
               done = 0;
               mode = MODE_JOG;
            end
            FUNC_STOP: begin
               if (mode != MODE_IDLE) begin
                  mode = MODE_STOP;
                  done = 0;
               end
            end
            default: sample_tick();
         endcase
         r.position = position[VAL_W-1:0];
         r.velocity = velocity[VAL_W-1:0];
         r.motor = VAL_W'(sat32(scaled_mul(velocity, rotary, 16)));
         r.mode = mode;
         r.reached = done;
         expected_q = {expected_q, r};
      endfunction

      function void check_result(motion_result_type got);
         motion_result_type exp_r;
         results_seen++;
         if (got.reached) reached_seen++;
         if (expected_q.size() == 0) begin
            $error("result with no item waiting: position %0d", got.position);
            errors++;
            return;
         end
         exp_r = expected_q.pop_front();
         if (got.position !== exp_r.position) begin
            $error("position_out: expected %0d, got %0d", exp_r.position, got.position);
            errors++;
         end
         if (got.velocity !== exp_r.velocity) begin
            $error("velocity_out: expected %0d, got %0d", exp_r.velocity, got.velocity);
            errors++;
         end
         if (got.motor !== exp_r.motor) begin
            $error("motor_speed: expected %0d, got %0d", exp_r.motor, got.motor);
            errors++;
         end
         if (got.mode !== exp_r.mode) begin
            $error("mode_out: expected %0d, got %0d", exp_r.mode, got.mode);
            errors++;
         end
         if (got.reached !== exp_r.reached) begin
            $error("reached: expected %0d, got %0d", exp_r.reached, got.reached);
            errors++;
         end
      endfunction
   endclass

   logic                    clock = 0;
   logic                    reset = 1;
   logic                    req_valid = 0;
   logic                    req_ready;
   logic [FUNC_W-1:0]       req_func = FUNC_TICK;
   logic signed [VAL_W-1:0] req_goal = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 0;
   logic signed [VAL_W-1:0] rsp_position_out;
   logic signed [VAL_W-1:0] rsp_velocity_out;
   logic signed [VAL_W-1:0] rsp_motor_speed;
   logic [MODE_W-1:0]       rsp_mode_out;
   logic                    rsp_reached;
   logic                    csr_wen = 0;
   logic [IDX_W-1:0]        csr_index = '0;
   logic [CSR_W-1:0]        csr_wdata = '0;

   motion_scoreboard_type sb = new();
   bit no_idle = 0;
   bit hold_request = 0;
   int items_sent = 0;
   int idle_cycles = 0;

   trapezoidal_motion_profile_core i_dut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   // Watchdog: end the run when no item moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("FAIL trapezoidal_motion_profile_core");
            $finish;
         end
      end
   end

   // Receiver: random stall before each result, or a long hold-off when asked.
   initial begin
      int stall;
      motion_result_type got;
      @(negedge reset);
      @(posedge clock);
      forever begin
         if (hold_request) begin
            stall = LONG_HOLD;
            hold_request = 0;
         end else begin
            stall = no_idle ? 0 : $urandom_range(0, 18);
         end
         if (stall > 0) begin
            rsp_ready <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1;
         do @(posedge clock); while (!rsp_valid);
         got.position = rsp_position_out;
         got.velocity = rsp_velocity_out;
         got.motor = rsp_motor_speed;
         got.mode = rsp_mode_out;
         got.reached = rsp_reached;
         sb.check_result(got);
      end
   end

   // Offer one item after a random gap and hold it until it is accepted.
   task automatic send_item(logic [FUNC_W-1:0] func, logic signed [VAL_W-1:0] goal);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_func <= func;
      req_goal <= goal;
      do @(posedge clock); while (!req_ready);
      sb.note_item(func, goal);
      items_sent++;
   endtask

   // Drop valid and wait until every queued result has come back.
   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   // One register write, with the enable dropped again afterwards.
   task automatic write_reg(logic [IDX_W-1:0] idx, logic [CSR_W-1:0] value);
      csr_wen <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 0;
      sb.write_reg(idx, value);
      @(posedge clock);
   endtask

   task automatic load_regs(logic [CSR_W-1:0] vl, logic [CSR_W-1:0] al, logic [CSR_W-1:0] ts,
                            logic [CSR_W-1:0] tr, logic [CSR_W-1:0] rs);
      write_reg(REG_VEL_LIMIT, vl);
      write_reg(REG_ACCEL_LIMIT, al);
      write_reg(REG_TICK_SEC, ts);
      write_reg(REG_TICK_RATE, tr);
      write_reg(REG_ROTARY, rs);
   endtask

   task automatic send_ticks(int n);
      for (int i = 0; i < n; i++) send_item(FUNC_TICK, $urandom);
   endtask

   // Random traffic: mostly moves and jogs followed by ticks, plus noise items.
   task automatic random_phase(int count, int span);
      int first, pick;
      logic signed [VAL_W-1:0] g;
      first = items_sent;
      while (items_sent - first < count) begin
         pick = $urandom_range(0, 99);
         g = $signed($urandom_range(0, 2 * span)) - span;
         if (pick < 55) begin
            send_item(pick < 30 ? FUNC_ABS : FUNC_REL, g);
            send_ticks($urandom_range(3, 30));
            if ($urandom_range(0, 3) == 0) begin
               send_item(FUNC_STOP, $urandom);
               send_ticks($urandom_range(1, 10));
            end
         end else if (pick < 75) begin
            send_item(FUNC_JOG, pick < 72 ? g : $urandom);
            send_ticks($urandom_range(2, 15));
            send_item(FUNC_STOP, $urandom);
            send_ticks($urandom_range(2, 15));
         end else begin
            send_item(FUNC_W'($urandom_range(0, 7)), $urandom);
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: idle tick and stop, moves to here and away, jogs at both extremes,
      // spare function codes, and goals at the ends of the range.
      send_item(FUNC_TICK, '0);
      send_item(FUNC_STOP, '0);
      send_item(FUNC_ABS, '0);
      send_item(FUNC_TICK, '0);
      send_item(FUNC_ABS, 32'sh0001_0000);
      send_ticks(3);
      send_item(FUNC_REL, -32'sh0000_8000);
      send_ticks(2);
      send_item(FUNC_JOG, 32'sh7FFF_FFFF);
      send_ticks(2);
      send_item(FUNC_JOG, 32'sh8000_0000);
      send_ticks(1);
      send_item(FUNC_STOP, '0);
      send_ticks(1);
      send_item(3'd5, '1);
      send_item(3'd6, '0);
      send_item(3'd7, '1);
      send_item(FUNC_ABS, 32'sh7FFF_FFFF);
      send_item(FUNC_REL, 32'sh8000_0000);
      send_ticks(2);
      drain();

      // Defaults, with a long hold-off on the result side while items keep coming.
      hold_request = 1;
      random_phase(PHASE_ITEMS, 32'sh0000_4000);
      drain();

      // Fast profile so that moves finish and the target is reached.
      load_regs(31'h4_0000, 31'h8_0000, 31'h40_0000, 31'h4_0000, 31'h1_0000);
      write_reg(3'd7, '1);
      random_phase(PHASE_ITEMS, 32'sh0008_0000);
      drain();

      // Every register at its top value.
      load_regs('1, '1, '1, '1, '1);
      random_phase(PHASE_ITEMS, 32'sh7FFF_FFFF);
      drain();

      // Every register at its bottom nonzero value, rotary at zero, without idling.
      no_idle = 1;
      load_regs(31'd1, 31'd1, 31'd1, 31'd1, '0);
      random_phase(PHASE_ITEMS, 32'sh0001_0000);
      drain();
      no_idle = 0;

      // Random mid-range settings.
      load_regs(CSR_W'($urandom_range(1, 31'h00FF_FFFF)),
                CSR_W'($urandom_range(1, 31'h00FF_FFFF)),
                CSR_W'($urandom_range(1, 24'hFF_FFFF)),
                CSR_W'($urandom_range(1, 31'h00FF_FFFF)),
                CSR_W'($urandom_range(0, 31'h0004_0000)));
      random_phase(PHASE_ITEMS, 32'sh0010_0000);
      drain();

      // Back to a quick profile for the last stretch.
      load_regs(31'h2_0000, 31'h10_0000, 31'h20_0000, 31'h8_0000, 31'h3_0000);
      random_phase(PHASE_ITEMS, 32'sh0004_0000);
      drain();

      $display("Covered %0d items over six register settings; %0d results, %0d at target.",
               items_sent, sb.results_seen, sb.reached_seen);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("PASS trapezoidal_motion_profile_core");
      end else begin
         $display("FAIL trapezoidal_motion_profile_core");
      end
      $finish;
   end
endmodule

// ----- filelist.f -----
rtl/tmp_pkg.sv
rtl/tmp_mul.sv
rtl/trapezoidal_motion_profile_core.sv
tb/tb_trapezoidal_motion_profile_core.sv
